// ===== rtl/core/ptl_pkg.sv =====
// shared types, widths and state codes for the path tail truncation core
`default_nettype none

package ptl_pkg;

    // path storage
    localparam int MAX_POSES = 1024;
    localparam int ADDR_W    = $clog2(MAX_POSES);
    localparam int CNT_W     = $clog2(MAX_POSES + 1);

    // field widths
    localparam int COORD_W = 24;
    localparam int KEPT_W  = 11;
    localparam int DIST_W  = 32;

    // arithmetic widths
    localparam int ABS_W      = COORD_W;
    localparam int SQ_W       = 2 * ABS_W;
    localparam int RAD_W      = 2 * ((SQ_W + 2) / 2);
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 3;
    localparam int SQRT_ITER  = RAD_W / 2;
    localparam int SQRT_CNT_W = $clog2(SQRT_ITER);
    localparam int SUM_W      = 40;

    // configuration port
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_TAIL_ADDR = '0;
    localparam logic [DIST_W-1:0] TAIL_DIST_RESET = DIST_W'(256);

    // request payload
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      is_last;
    } t_req;

    // result payload
    typedef struct packed {
        logic [KEPT_W-1:0] kept_count;
        logic              overflowed;
    } t_res;

    // one stored pose
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_pose;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_LOAD,
        S_FETCH,
        S_DIFF,
        S_SQX,
        S_SQY,
        S_ROOT,
        S_WAIT,
        S_ACC,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/ptl_pose_mem.sv =====
// pose memory: one write port, one registered read port
`default_nettype none

module ptl_pose_mem
    import ptl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_pose             i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_pose                  o_rdata
);

    t_pose r_mem [MAX_POSES];
    t_pose r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/ptl_isqrt.sv =====
// iterative floor square root, one result bit per cycle
`default_nettype none

module ptl_isqrt
    import ptl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic                   o_done,
    output logic [ROOT_W-1:0]      o_root
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [SQRT_CNT_W-1:0] r_cnt, n_cnt;
    logic [RAD_W-1:0]      r_rad, n_rad;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [ROOT_W-1:0]     r_root, n_root;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;

    // one digit step: bring down two radicand bits, try to subtract
    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = REM_W'({r_root, 2'b01});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = SQRT_CNT_W'(SQRT_ITER - 1);
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = {r_rad[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== rtl/core/path_truncate_by_tail_length_core.sv =====
// path tail truncation core: pose store, walk sequencer, squarer, square root, accumulator
//
//   channel   | handshake             | payload
//   ----------+-----------------------+----------------------------------
//   request   | start, busy           | i_req  (pos_x, pos_y, is_last)
//   result    | o_done (1-cycle pulse)| o_res  (kept_count, overflowed)
//   config    | psel, penable, pwrite | paddr, pwdata, prdata, pready
//
// a pose without is_last is stored and busy stays low. a final pose
// starts the backward walk: each segment is read, differenced, squared
// twice on the shared multiplier, rooted in the one-bit-per-cycle square
// root and accumulated.
// the result is shown for exactly one cycle; the receiver cannot stall.
// reset is synchronous, active low, and empties the path.
`default_nettype none

module path_truncate_by_tail_length_core
    import ptl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_req              i_req,
    output logic                   o_done,
    output t_res                   o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_walk;
    logic [CNT_W-1:0]   r_kept;
    logic [DIST_W-1:0]  r_tail;
    logic [SUM_W-1:0]   r_sum;
    t_pose              r_a;
    logic [ABS_W-1:0]   r_dx, r_dy;
    logic [SQ_W-1:0]    r_sq, r_prod;

    logic               accept;
    logic               room;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_raddr;
    t_pose              mem_wdata;
    t_pose              mem_rdata;
    logic               sq_start;
    logic               sq_done;
    logic [ROOT_W-1:0]  sq_root;
    logic [RAD_W-1:0]   rad;
    logic [ABS_W-1:0]   mul_op;
    logic [SQ_W-1:0]    mul_out;
    logic [COORD_W:0]   diff_x, diff_y;
    logic [SUM_W:0]     sum_wide;
    logic [SUM_W-1:0]   sum_sat;
    logic               reached;
    logic               cfg_sel;
    logic               cfg_wr;

    assign accept = start && !busy;
    assign room   = (r_count < CNT_W'(MAX_POSES));

    // pose store
    assign mem_we          = accept && room;
    assign mem_wdata.x     = i_req.pos_x;
    assign mem_wdata.y     = i_req.pos_y;

    ptl_pose_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // square root unit on the summed squares
    assign rad = RAD_W'(r_sq) + RAD_W'(r_prod);

    ptl_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // segment differences, magnitudes
    assign diff_x = {r_a.x[COORD_W-1], r_a.x} - {mem_rdata.x[COORD_W-1], mem_rdata.x};
    assign diff_y = {r_a.y[COORD_W-1], r_a.y} - {mem_rdata.y[COORD_W-1], mem_rdata.y};

    // shared squarer
    assign mul_op  = (r_state == S_SQX) ? r_dx : r_dy;
    assign mul_out = mul_op * mul_op;

    // saturating accumulate and distance compare
    assign sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(sq_root);
    assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    assign reached  = (sum_sat >= SUM_W'(r_tail));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_req.is_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (r_count < CNT_W'(2)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD:  n_state = S_FETCH;
            S_FETCH: n_state = S_DIFF;
            S_DIFF:  n_state = S_SQX;
            S_SQX:   n_state = S_SQY;
            S_SQY:   n_state = S_ROOT;
            S_ROOT:  n_state = S_WAIT;
            S_WAIT: begin
                if (sq_done) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                if (reached || r_walk == CNT_W'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        busy      = 1'b1;
        o_done    = 1'b0;
        sq_start  = 1'b0;
        mem_raddr = ADDR_W'(r_walk - CNT_W'(1));
        case (r_state)
            S_IDLE:  busy = 1'b0;
            S_START: mem_raddr = ADDR_W'(r_count - CNT_W'(1));
            S_ROOT:  sq_start = 1'b1;
            S_DONE:  o_done = 1'b1;
            default: ;
        endcase
    end

    // state register and path bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (accept) begin
                if (room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_START: begin
                r_sum  <= '0;
                r_kept <= r_count;
                r_walk <= r_count - CNT_W'(1);
            end
            S_LOAD: r_a <= mem_rdata;
            S_DIFF: begin
                r_dx <= diff_x[COORD_W] ? ABS_W'(-diff_x) : ABS_W'(diff_x);
                r_dy <= diff_y[COORD_W] ? ABS_W'(-diff_y) : ABS_W'(diff_y);
                r_a  <= mem_rdata;
            end
            S_SQX: r_sq   <= mul_out;
            S_SQY: r_prod <= mul_out;
            S_ACC: begin
                r_sum <= sum_sat;
                if (reached) begin
                    r_kept <= r_walk;
                end else begin
                    r_walk <= r_walk - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // configuration register, decoded at the tail distance address
    assign cfg_sel = (paddr == REG_TAIL_ADDR);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= TAIL_DIST_RESET;
        end else if (cfg_wr) begin
            r_tail <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = cfg_sel ? r_tail : '0;

    // result
    assign o_res.kept_count = KEPT_W'(r_kept);
    assign o_res.overflowed = r_ovf;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// self-checking testbench for the path tail truncation core
module tb
    import ptl_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] SUM_MAX = (64'd1 << SUM_W) - 64'd1;
    localparam int MAX_BAD_SHOWN = 10;
    localparam int SETTLE_CYCLES = 48;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              start    = 1'b0;
    logic              busy;
    t_req              i_req    = '0;
    logic              o_done;
    t_res              o_res;
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [APB_AW-1:0] paddr    = '0;
    logic [APB_DW-1:0] pwdata   = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    path_truncate_by_tail_length_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of the path store and distance register
    logic signed [COORD_W-1:0] path_x [MAX_POSES];
    logic signed [COORD_W-1:0] path_y [MAX_POSES];
    int                        pose_cnt  = 0;
    logic                      pose_ovf  = 1'b0;
    logic [DIST_W-1:0]         tail_dist = TAIL_DIST_RESET;

    t_req pose_q [$];
    t_res kept_q [$];
    int   n_queued   = 0;
    int   n_accepted = 0;
    int   n_bad      = 0;
    int   idle_pct   = 18;
    bit   req_taken  = 1'b0;

    // floor integer square root
    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // length of the segment between stored poses a and b
    function automatic logic [63:0] seg_len(int a, int b);
        longint dx;
        longint dy;
        dx = longint'(path_x[a]) - longint'(path_x[b]);
        dy = longint'(path_y[a]) - longint'(path_y[b]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return floor_root(64'(dx * dx + dy * dy));
    endfunction

    // number of leading poses left after cutting the tail
    function automatic logic [KEPT_W-1:0] tail_cut();
        int          idx;
        bit          hit;
        logic [63:0] acc;
        logic [63:0] len;
        logic [KEPT_W-1:0] kept;
        kept = KEPT_W'(pose_cnt);
        hit  = 1'b0;
        acc  = '0;
        if (pose_cnt >= 2) begin
            for (idx = pose_cnt - 1; idx > 0 && !hit; idx--) begin
                len = seg_len(idx, idx - 1);
                acc = (len > SUM_MAX - acc) ? SUM_MAX : acc + len;
                if (acc >= 64'(tail_dist)) begin
                    kept = KEPT_W'(idx);
                    hit  = 1'b1;
                end
            end
        end
        return kept;
    endfunction

    // fold one accepted pose into the predictor
    function automatic void take_pose(t_req r);
        t_res want;
        if (pose_cnt < MAX_POSES) begin
            path_x[pose_cnt] = r.pos_x;
            path_y[pose_cnt] = r.pos_y;
            pose_cnt++;
        end else begin
            pose_ovf = 1'b1;
        end
        if (r.is_last) begin
            want.kept_count = tail_cut();
            want.overflowed = pose_ovf;
            kept_q.push_back(want);
            pose_cnt = 0;
            pose_ovf = 1'b0;
        end
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !req_taken) begin
            // hold the request until taken
        end else begin
            req_taken = 1'b0;
            if (pose_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_req <= pose_q.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // result checker and request capture
    always @(posedge i_clk) begin : monitor
        t_res want;
        if (i_rst_n) begin
            if (o_done) begin
                if (kept_q.size() == 0) begin
                    if (n_bad < MAX_BAD_SHOWN)
                        $display("unexpected result: kept_count %0d overflowed %0d",
                                 o_res.kept_count, o_res.overflowed);
                    n_bad++;
                end else begin
                    want = kept_q.pop_front();
                    if (o_res.kept_count !== want.kept_count ||
                        o_res.overflowed !== want.overflowed) begin
                        if (n_bad < MAX_BAD_SHOWN)
                            $display(
                                "mismatch: kept_count exp %0d got %0d, overflowed exp %0d got %0d",
                                want.kept_count, o_res.kept_count,
                                want.overflowed, o_res.overflowed);
                        n_bad++;
                    end
                end
            end
            if (start && !busy) begin
                take_pose(i_req);
                n_accepted++;
                req_taken = 1'b1;
            end
        end
    end

    // queue one pose request
    task automatic push_pose(int x, int y, bit last);
        t_req r;
        r.pos_x   = COORD_W'(x);
        r.pos_y   = COORD_W'(y);
        r.is_last = last;
        pose_q.push_back(r);
        n_queued++;
    endtask

    // queue a path of n poses; step scale s, negative picks one at random
    task automatic queue_path(int n, int s);
        int k;
        int px;
        int py;
        bit wild;
        if (s < 0) s = $urandom_range(23);
        wild = ($urandom_range(9) == 0);
        px   = $urandom;
        py   = $urandom;
        for (k = 0; k < n; k++) begin
            if (wild) begin
                px = $urandom;
                py = $urandom;
            end else if (k > 0) begin
                px += int'($urandom_range(2 << s)) - (1 << s);
                py += int'($urandom_range(2 << s)) - (1 << s);
            end
            push_pose(px, py, k == n - 1);
        end
    endtask

    // wait until every request is taken and every result is back
    task automatic drain();
        while (n_accepted != n_queued || kept_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // apb write of the tail distance register
    task automatic write_tail(logic [DIST_W-1:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TAIL_ADDR;
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        tail_dist = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stimulus sequence
    initial begin
        logic [DIST_W-1:0] dists [9];
        int p;
        int n;
        int goal;
        dists = '{32'd1, 32'd256, 32'd4096, 32'h0001_0000, 32'h0010_0000,
                  32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
        dists[6] = $urandom;
        dists[7] = $urandom_range(1 << 20);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset distance of 256: single pose, exact hit, just short, extremes
        push_pose(8388607, -8388608, 1'b1);
        push_pose(0, 0, 1'b0);
        push_pose(256, 0, 1'b1);
        push_pose(0, 0, 1'b0);
        push_pose(0, 255, 1'b1);
        push_pose(-8388608, -8388608, 1'b0);
        push_pose(8388607, 8388607, 1'b1);
        // zero-length segments never reach the distance
        push_pose(5, 5, 1'b0);
        push_pose(5, 5, 1'b0);
        push_pose(5, 5, 1'b1);
        // cut on an early and on the last segment
        push_pose(0, 0, 1'b0);
        push_pose(100, 0, 1'b0);
        push_pose(200, 0, 1'b0);
        push_pose(300, 0, 1'b1);
        push_pose(0, 0, 1'b0);
        push_pose(1000, 0, 1'b0);
        push_pose(2000, 0, 1'b0);
        push_pose(2300, 0, 1'b1);
        drain();

        // zero distance drops the final pose of any path with two or more poses
        write_tail('0);
        push_pose(7, 7, 1'b0);
        push_pose(7, 7, 1'b1);
        push_pose(3, 3, 1'b1);
        push_pose(0, 0, 1'b0);
        push_pose(9, 9, 1'b0);
        push_pose(-9, 40, 1'b1);
        drain();

        // random paths over several distance settings
        for (p = 0; p < 9; p++) begin
            write_tail(dists[p]);
            idle_pct = (p == 3) ? 0 : 18;
            // past capacity sets the overflow flag; with a long distance a non-wild path keeps every stored pose
            if (dists[p] == 32'hFFFF_FFFF) queue_path(MAX_POSES + 3, 4);
            goal = n_queued + 60;
            while (n_queued < goal) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 1);
                queue_path(n, -1);
            end
            drain();
        end

        if (n_bad == 0) begin
            $display("path_truncate_by_tail_length_core verification clean");
        end else begin
            $display("path_truncate_by_tail_length_core verification failed");
        end
        $finish;
    end

    // run time limit
    initial begin
        #5_000_000;
        $display("path_truncate_by_tail_length_core verification failed");
        $finish;
    end

endmodule
